@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the translator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property checked on every rising clock edge outside reset.
`define SAT_ASSERT(lbl, ck, rn, prop, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (prop)) else $error(msg);

// Same-cycle implication.
`define SAT_ASSERT_IMPL(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define SAT_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/sat_pkg.sv @@
// Package with types and constants of the section address translator.
`timescale 1ns / 1ps

package sat_pkg;

    localparam int SAT_MAX_SECTIONS = 16;

    // Request command codes.
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_V2F   = 2'd1;
    localparam logic [1:0] CMD_F2V   = 2'd2;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [3:0]  entry_index;
        logic [31:0] region_virtual_base;
        logic [31:0] region_virtual_size;
        logic [31:0] region_file_offset;
        logic [31:0] region_raw_size;
        logic [31:0] query_address;
    } sat_req_t;

    typedef struct packed {
        logic [31:0] translated_address;
        logic        hit;
        logic [3:0]  matched_entry;
    } sat_rsp_t;

    typedef struct packed {
        logic [31:0] virtual_base;
        logic [31:0] virtual_size;
        logic [31:0] file_offset;
        logic [31:0] raw_size;
    } sat_entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FINISH
    } sat_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic start_walk;
        logic step;
        logic load_rsp;
    } sat_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic translate;
        logic count_zero;
        logic hit;
        logic last;
        logic rsp_free;
    } sat_status_t;

endpackage

@@ hw/rtl/section_address_translator.sv @@
// Top level of the section address translator.
//
// Requests arrive on req with req_valid; the block raises req_stall while it
// works on a translation. A request with cmd write loads one table entry in the
// cycle it is accepted and gives no result; cmd 3 is dropped likewise.
// A translate request walks the table one entry per cycle, from entry 0, up to
// min(section_count, MAX_SECTIONS) entries, and stops at the first region that
// holds the query address. With section_count zero no entry is read and the
// miss result goes straight to the finish state. The single-port table read
// with its registered data sets the walk rate. Results are held in an output
// register on rsp with rsp_valid; a stalled result stays put, and the block
// still accepts a new request meanwhile, holding the next finished result
// until the register is free. The user must write section_count through
// cfg_write_en and cfg_write_data only while idle; the block itself leaves this
// unchecked. Reset clears the state machine, the output valid and section_count;
// table entries hold no reset value and must be written before they are
// searched.
`timescale 1ns / 1ps

module section_address_translator #(
    parameter int MAX_SECTIONS = sat_pkg::SAT_MAX_SECTIONS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  sat_pkg::sat_req_t req,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output sat_pkg::sat_rsp_t rsp,
    input  logic              cfg_write_en,
    input  logic [4:0]        cfg_write_data
);
    import sat_pkg::*;

    sat_cmd_t    cmd;
    sat_status_t status;

    sat_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .status    (status),
        .cmd       (cmd)
    );

    sat_datapath #(
        .MAX_SECTIONS (MAX_SECTIONS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .req            (req),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .cmd            (cmd),
        .status         (status),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .rsp            (rsp)
    );

endmodule

@@ hw/rtl/sat_ctrl.sv @@
// Controller state machine of the section address translator.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sat_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  sat_pkg::sat_status_t status,
    output sat_pkg::sat_cmd_t    cmd
);
    import sat_pkg::*;

    sat_state_t state_reg;
    sat_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_stall  = (state_reg != ST_IDLE);
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.accept = 1'b1;
                    if (status.translate)
                    begin
                        // With no entries in use the miss result is ready at once.
                        if (status.count_zero)
                        begin
                            state_next = ST_FINISH;
                        end
                        else
                        begin
                            cmd.start_walk = 1'b1;
                            state_next     = ST_WALK;
                        end
                    end
                end
            end
            ST_WALK:
            begin
                cmd.step = 1'b1;
                if (status.hit || status.last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (status.rsp_free)
                begin
                    cmd.load_rsp = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `SAT_ASSERT_IMPL(a_load_needs_free, clk, rst_n, cmd.load_rsp, status.rsp_free, "result loaded while output busy")
    `SAT_ASSERT_NEXT(a_hit_finishes, clk, rst_n, state_reg == ST_WALK && status.hit, state_reg == ST_FINISH, "hit did not end the walk")
    `SAT_ASSERT_NEXT(a_zero_count_miss, clk, rst_n, cmd.accept && status.translate && status.count_zero, state_reg == ST_FINISH, "empty table did not finish at once")

endmodule

@@ hw/rtl/sat_datapath.sv @@
// Datapath of the section address translator: region table, walk counter, result register.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sat_datapath #(
    parameter int MAX_SECTIONS = sat_pkg::SAT_MAX_SECTIONS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sat_pkg::sat_req_t    req,
    input  logic                 cfg_write_en,
    input  logic [4:0]           cfg_write_data,
    input  sat_pkg::sat_cmd_t    cmd,
    output sat_pkg::sat_status_t status,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output sat_pkg::sat_rsp_t    rsp
);
    import sat_pkg::*;

    localparam int IDX_W = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
    localparam int CNT_W = $clog2(MAX_SECTIONS + 1);

    sat_entry_t        table_mem [MAX_SECTIONS];
    sat_entry_t        entry_rd_reg;
    logic [IDX_W-1:0]  rd_idx_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic [4:0]        section_count_reg;
    logic [1:0]        op_reg;
    logic [31:0]       addr_reg;
    logic [31:0]       result_reg;
    logic              hit_reg;
    logic [3:0]        match_reg;
    logic              rsp_valid_reg;
    sat_rsp_t          rsp_reg;

    logic [CNT_W-1:0]  limit;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    logic [31:0]       this_base;
    logic [31:0]       this_size;
    logic [31:0]       other_base;
    logic [32:0]       region_end;
    logic              match;
    logic [31:0]       rebased;

    // A count above the table depth searches the whole table.
    always_comb
    begin
        if (32'(section_count_reg) > 32'(MAX_SECTIONS))
        begin
            limit = CNT_W'(MAX_SECTIONS);
        end
        else
        begin
            limit = CNT_W'(section_count_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            section_count_reg <= 5'd0;
        end
        else if (cfg_write_en)
        begin
            section_count_reg <= cfg_write_data;
        end
    end

    // Writes to entries beyond the table are dropped.
    assign wr_en = cmd.accept && (req.cmd == CMD_WRITE)
                   && (32'(req.entry_index) < 32'(MAX_SECTIONS));

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_mem[IDX_W'(req.entry_index)] <= '{
                virtual_base: req.region_virtual_base,
                virtual_size: req.region_virtual_size,
                file_offset:  req.region_file_offset,
                raw_size:     req.region_raw_size
            };
        end
    end

    assign rd_en   = cmd.start_walk || (cmd.step && !status.last && !match);
    assign rd_addr = cmd.start_walk ? '0 : cnt_reg[IDX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            entry_rd_reg <= table_mem[rd_addr];
            rd_idx_reg   <= rd_addr;
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.start_walk)
        begin
            cnt_next = CNT_W'(1);
        end
        else if (cmd.step && !status.last)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // Region test and rebase on the entry read in the previous cycle.
    always_comb
    begin
        if (op_reg == CMD_V2F)
        begin
            this_base  = entry_rd_reg.virtual_base;
            this_size  = entry_rd_reg.virtual_size;
            other_base = entry_rd_reg.file_offset;
        end
        else
        begin
            this_base  = entry_rd_reg.file_offset;
            this_size  = entry_rd_reg.raw_size;
            other_base = entry_rd_reg.virtual_base;
        end
        region_end = {1'b0, this_base} + {1'b0, this_size};
        match      = (addr_reg >= this_base) && ({1'b0, addr_reg} < region_end);
        rebased    = other_base + (addr_reg - this_base);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg     <= req.cmd;
            addr_reg   <= req.query_address;
            result_reg <= req.query_address;
            hit_reg    <= 1'b0;
            match_reg  <= 4'd0;
        end
        else if (cmd.step && match)
        begin
            result_reg <= rebased;
            hit_reg    <= 1'b1;
            match_reg  <= 4'(rd_idx_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.load_rsp)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_rsp)
        begin
            rsp_reg <= '{translated_address: result_reg, hit: hit_reg, matched_entry: match_reg};
        end
    end

    assign status.translate  = (req.cmd == CMD_V2F) || (req.cmd == CMD_F2V);
    assign status.count_zero = (section_count_reg == 5'd0);
    assign status.hit        = match;
    assign status.last       = (cnt_reg == limit);
    assign status.rsp_free   = !rsp_valid_reg || !rsp_stall;

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `SAT_ASSERT_NEXT(a_load_sets_valid, clk, rst_n, cmd.load_rsp, rsp_valid_reg, "loaded result not valid")
    `SAT_ASSERT_IMPL(a_walk_in_range, clk, rst_n, cmd.step, cnt_reg <= limit && cnt_reg != '0, "walk counter out of range")
    `SAT_ASSERT_NEXT(a_read_follows_cnt, clk, rst_n, cmd.step && !status.last && !match, rd_idx_reg == $past(cnt_reg[IDX_W-1:0]), "walk read wrong entry")

endmodule
